@@ hw/rtl/fdss_pkg.sv @@
// Shared types and constants for the four-digit segment display sender.
// No dependencies.
package fdss_pkg;

  typedef enum logic [1:0] {
    SYM_START = 2'd0,
    SYM_BIT   = 2'd1,
    SYM_STOP  = 2'd2
  } sym_kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef struct packed {
    logic [7:0] seg3;
    logic [7:0] seg2;
    logic [7:0] seg1;
    logic [7:0] seg0;
    logic [7:0] addr;
  } frame_rec_t;

  localparam int unsigned REC_W = $bits(frame_rec_t);

  localparam logic [1:0] CFG_DATA_CMD = 2'd0;
  localparam logic [1:0] CFG_DISP_CMD = 2'd1;

  localparam logic [15:0] VALUE_MAX = 16'd9999;
  localparam int unsigned BIN_W     = 14;
  localparam logic [3:0]  CONV_LAST = 4'd13;

  localparam logic [5:0] POS_START0     = 6'd0;
  localparam logic [5:0] POS_DATA_FIRST = 6'd1;
  localparam logic [5:0] POS_DATA_LAST  = 6'd8;
  localparam logic [5:0] POS_STOP0      = 6'd9;
  localparam logic [5:0] POS_START1     = 6'd10;
  localparam logic [5:0] POS_PAY_FIRST  = 6'd11;
  localparam logic [5:0] POS_PAY_LAST   = 6'd50;
  localparam logic [5:0] POS_STOP1      = 6'd51;
  localparam logic [5:0] POS_START2     = 6'd52;
  localparam logic [5:0] POS_DISP_FIRST = 6'd53;
  localparam logic [5:0] POS_DISP_LAST  = 6'd60;
  localparam logic [5:0] POS_LAST       = 6'd61;

  function automatic logic [7:0] seg_code(input logic [3:0] digit);
    logic [7:0] code;
    unique case (digit)
      4'd0:    code = 8'h3f;
      4'd1:    code = 8'h06;
      4'd2:    code = 8'h5b;
      4'd3:    code = 8'h4f;
      4'd4:    code = 8'h66;
      4'd5:    code = 8'h6d;
      4'd6:    code = 8'h7d;
      4'd7:    code = 8'h07;
      4'd8:    code = 8'h7f;
      4'd9:    code = 8'h6f;
      default: code = 8'h00;
    endcase
    return code;
  endfunction

endpackage

@@ hw/rtl/fdss_front.sv @@
// Front end: accepts items, saturates the value and converts it to four
// BCD digits by shift-and-add-3, one bit per cycle. Depends on fdss_pkg.
module fdss_front
  import fdss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [15:0] in_value,
  input  logic [7:0] in_start_address,
  input  logic       q_full,
  output logic       busy,
  output logic       q_push,
  output frame_rec_t q_rec
);

  front_state_t state_r, state_nxt;
  logic [3:0]       cnt_r;
  logic [BIN_W-1:0] bin_r;
  logic [15:0]      bcd_r;
  logic [7:0]       addr_r;
  logic [15:0]      bcd_adj;
  logic [15:0]      sat_value;
  logic             accept;

  function automatic logic [3:0] add3(input logic [3:0] d);
    return (d >= 4'd5) ? d + 4'd3 : d;
  endfunction

  assign accept    = start && !busy;
  assign sat_value = (in_value > VALUE_MAX) ? VALUE_MAX : in_value;
  assign bcd_adj   = {add3(bcd_r[15:12]), add3(bcd_r[11:8]),
                      add3(bcd_r[7:4]), add3(bcd_r[3:0])};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_CONV;
      F_CONV: if (cnt_r == CONV_LAST) state_nxt = F_PUSH;
      F_PUSH: if (!q_full) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state_r != F_IDLE);
    q_push = (state_r == F_PUSH) && !q_full;
    q_rec.addr = addr_r;
    q_rec.seg0 = seg_code(bcd_r[15:12]);
    q_rec.seg1 = seg_code(bcd_r[11:8]);
    q_rec.seg2 = seg_code(bcd_r[7:4]);
    q_rec.seg3 = seg_code(bcd_r[3:0]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == F_CONV) begin
        cnt_r <= cnt_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      bin_r  <= sat_value[BIN_W-1:0];
      bcd_r  <= '0;
      addr_r <= in_start_address;
    end else if (state_r == F_CONV) begin
      bcd_r <= {bcd_adj[14:0], bin_r[BIN_W-1]};
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
    end
  end

endmodule

@@ hw/rtl/fdss_queue.sv @@
// Two-entry queue of frame records between front and back end.
// Depends on fdss_pkg.
module fdss_queue
  import fdss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  frame_rec_t push_rec,
  input  logic       pop,
  output frame_rec_t head_rec,
  output logic       full,
  output logic       empty
);

  frame_rec_t mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full     = (count_r == 2'd2);
  assign empty    = (count_r == 2'd0);
  assign head_rec = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_rec;
  end

endmodule

@@ hw/rtl/fdss_back.sv @@
// Back end: serializes one frame record into 62 line symbols, one per cycle,
// through a registered output stage. Depends on fdss_pkg.
module fdss_back
  import fdss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  frame_rec_t q_rec,
  input  logic [7:0] data_command,
  input  logic [7:0] display_command,
  output logic       q_pop,
  output logic       out_valid,
  output logic [1:0] out_symbol_kind,
  output logic       out_bit_value,
  output logic       out_last
);

  logic             active_r;
  logic [5:0]       cnt_r;
  logic [REC_W-1:0] shift_r;
  logic             valid_r;
  sym_kind_t        kind_r;
  logic             bit_r;
  logic             last_r;
  sym_kind_t        kind_nxt;
  logic             bit_nxt;
  logic [5:0]       data_off;
  logic [5:0]       disp_off;
  logic             in_payload;

  assign q_pop      = (!active_r || cnt_r == POS_LAST) && !q_empty;
  assign data_off   = cnt_r - POS_DATA_FIRST;
  assign disp_off   = cnt_r - POS_DISP_FIRST;
  assign in_payload = (cnt_r >= POS_PAY_FIRST) && (cnt_r <= POS_PAY_LAST);

  always_comb begin
    kind_nxt = SYM_BIT;
    bit_nxt  = 1'b0;
    priority if (cnt_r == POS_START0 || cnt_r == POS_START1 || cnt_r == POS_START2) begin
      kind_nxt = SYM_START;
    end else if (cnt_r == POS_STOP0 || cnt_r == POS_STOP1 || cnt_r == POS_LAST) begin
      kind_nxt = SYM_STOP;
    end else if (cnt_r >= POS_DATA_FIRST && cnt_r <= POS_DATA_LAST) begin
      bit_nxt = data_command[data_off[2:0]];
    end else if (in_payload) begin
      bit_nxt = shift_r[0];
    end else begin
      bit_nxt = display_command[disp_off[2:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      valid_r  <= 1'b0;
    end else begin
      valid_r <= active_r;
      if (q_pop) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        if (cnt_r == POS_LAST) begin
          active_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r + 6'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      shift_r <= q_rec;
    end else if (active_r && in_payload) begin
      shift_r <= shift_r >> 1;
    end
    kind_r <= kind_nxt;
    bit_r  <= bit_nxt;
    last_r <= (cnt_r == POS_LAST);
  end

  assign out_valid       = valid_r;
  assign out_symbol_kind = kind_r;
  assign out_bit_value   = bit_r;
  assign out_last        = last_r;

endmodule

@@ hw/rtl/four_digit_segment_display_sender.sv @@
// Four-digit segment display sender, top level: config registers, front end,
// queue and symbol serializer. Depends on fdss_pkg, fdss_front, fdss_queue, fdss_back.
// After start is taken the value is converted, queued and serialized; 62 symbols then
// follow on consecutive cycles; sustained throughput is set by the serializer.
// busy is high from an accepted start until its record is pushed to the queue.
// Reset clears control state and sets data_command to 0x40, display_command to 0x88.
module four_digit_segment_display_sender
  import fdss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_value,
  input  logic [7:0]  in_start_address,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  output logic        out_valid,
  output logic [1:0]  out_symbol_kind,
  output logic        out_bit_value,
  output logic        out_last
);

  logic [7:0] data_command_r;
  logic [7:0] display_command_r;
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  frame_rec_t push_rec;
  frame_rec_t head_rec;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_command_r    <= 8'h40;
      display_command_r <= 8'h88;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_DATA_CMD) data_command_r <= cfg_wdata;
      if (cfg_index == CFG_DISP_CMD) display_command_r <= cfg_wdata;
    end
  end

  fdss_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_value         (in_value),
    .in_start_address (in_start_address),
    .q_full           (q_full),
    .busy             (busy),
    .q_push           (q_push),
    .q_rec            (push_rec)
  );

  fdss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_rec (push_rec),
    .pop      (q_pop),
    .head_rec (head_rec),
    .full     (q_full),
    .empty    (q_empty)
  );

  fdss_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_rec           (head_rec),
    .data_command    (data_command_r),
    .display_command (display_command_r),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_symbol_kind (out_symbol_kind),
    .out_bit_value   (out_bit_value),
    .out_last        (out_last)
  );

endmodule
